// ----- hdl/wsd_pkg.sv -----
// ----------------------------------------------------------------------------
// wsd_pkg: shared types for the WebSocket frame deframer
// Result record passed from the header/payload parser to the output buffer.
// ----------------------------------------------------------------------------
package wsd_pkg;

  localparam logic KindHeader  = 1'b0;
  localparam logic KindPayload = 1'b1;

  typedef struct packed {
    logic        item_kind;
    logic [7:0]  payload_byte;
    logic [3:0]  message_opcode;
    logic [63:0] frame_length;
    logic        final_fragment;
    logic        message_end;
    logic        missing_fragment;
  } wsd_result_t;

endpackage

// ----- hdl/wsd_parser.sv -----
// ----------------------------------------------------------------------------
// wsd_parser: frame header and payload parser
// Consumes one byte per request, updates the frame state and produces at most
// one result (header completed or unmasked payload byte) in the same cycle.
// ----------------------------------------------------------------------------
module wsd_parser
  import wsd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        byte_valid_i,
  input  logic [7:0]  byte_i,
  output logic        res_valid_o,
  output wsd_result_t res_o
);

  typedef enum logic [2:0] {
    PhHdr0 = 3'd0,
    PhHdr1 = 3'd1,
    PhExt  = 3'd2,
    PhMask = 3'd3,
    PhBody = 3'd4
  } phase_e;

  localparam logic [6:0] LenCode16 = 7'h7E;
  localparam logic [6:0] LenCode64 = 7'h7F;

  phase_e      phase_q, phase_d;
  logic [3:0]  ext_left_q, ext_left_d;
  logic [63:0] len_acc_q, len_acc_d;
  logic [63:0] pay_left_q, pay_left_d;
  logic [7:0]  mask_key_q [4];
  logic [7:0]  mask_key_d [4];
  logic [1:0]  mask_idx_q, mask_idx_d;
  logic        masked_q, masked_d;
  logic        fin_q, fin_d;
  logic        prev_fin_q, prev_fin_d;
  logic [3:0]  opcode_q, opcode_d;
  logic [3:0]  held_op_q, held_op_d;

  logic        hdr_done;
  logic [63:0] hdr_len;
  logic [3:0]  hdr_op;
  logic [6:0]  len_code;
  logic [63:0] ext_len;
  logic [3:0]  ext_dec;
  logic [1:0]  mask_inc;
  logic [7:0]  key_byte;

  assign len_code = byte_i[6:0];
  assign ext_len  = {len_acc_q[55:0], byte_i};
  assign ext_dec  = ext_left_q - 4'd1;
  assign mask_inc = mask_idx_q + 2'd1;
  assign key_byte = mask_key_q[mask_idx_q];
  assign hdr_op   = (opcode_q != 4'd0) ? opcode_q : held_op_q;

  // Advance the frame state for one byte
  always_comb begin
    phase_d    = phase_q;
    ext_left_d = ext_left_q;
    len_acc_d  = len_acc_q;
    pay_left_d = pay_left_q;
    mask_key_d = mask_key_q;
    mask_idx_d = mask_idx_q;
    masked_d   = masked_q;
    fin_d      = fin_q;
    prev_fin_d = prev_fin_q;
    opcode_d   = opcode_q;
    held_op_d  = held_op_q;
    hdr_done   = 1'b0;
    hdr_len    = len_acc_q;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (byte_valid_i) begin
      case (phase_q)
        PhHdr1: begin
          masked_d  = byte_i[7];
          len_acc_d = 64'd0;
          if (len_code == LenCode16) begin
            ext_left_d = 4'd2;
            phase_d    = PhExt;
          end else if (len_code == LenCode64) begin
            ext_left_d = 4'd8;
            phase_d    = PhExt;
          end else begin
            len_acc_d = {57'd0, len_code};
            hdr_len   = {57'd0, len_code};
            if (byte_i[7]) begin
              mask_idx_d = 2'd0;
              phase_d    = PhMask;
            end else begin
              hdr_done = 1'b1;
            end
          end
        end
        PhExt: begin
          len_acc_d  = ext_len;
          hdr_len    = ext_len;
          ext_left_d = ext_dec;
          if (ext_dec == 4'd0) begin
            if (masked_q) begin
              mask_idx_d = 2'd0;
              phase_d    = PhMask;
            end else begin
              hdr_done = 1'b1;
            end
          end
        end
        PhMask: begin
          mask_key_d[mask_idx_q] = byte_i;
          mask_idx_d = mask_inc;
          if (mask_inc == 2'd0) begin
            hdr_done = 1'b1;
          end
        end
        PhBody: begin
          res_valid_o          = 1'b1;
          res_o.item_kind      = KindPayload;
          res_o.payload_byte   = masked_q ? (byte_i ^ key_byte) : byte_i;
          res_o.message_opcode = held_op_q;
          res_o.final_fragment = fin_q;
          mask_idx_d = mask_inc;
          pay_left_d = pay_left_q - 64'd1;
          if (pay_left_q == 64'd1) begin
            res_o.message_end = fin_q;
            phase_d           = PhHdr0;
          end
        end
        default: begin
          fin_d    = byte_i[7];
          opcode_d = byte_i[3:0];
          phase_d  = PhHdr1;
        end
      endcase

      // Close the header: resolve opcode, load payload count, emit header
      if (hdr_done) begin
        held_op_d  = hdr_op;
        prev_fin_d = fin_q;
        pay_left_d = hdr_len;
        mask_idx_d = 2'd0;
        phase_d    = (hdr_len == 64'd0) ? PhHdr0 : PhBody;
        res_valid_o            = 1'b1;
        res_o.item_kind        = KindHeader;
        res_o.message_opcode   = hdr_op;
        res_o.frame_length     = hdr_len;
        res_o.final_fragment   = fin_q;
        res_o.message_end      = fin_q && (hdr_len == 64'd0);
        res_o.missing_fragment = !prev_fin_q && fin_q && (opcode_q != 4'd0);
      end
    end
  end

  // Hold frame state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhHdr0;
      ext_left_q <= 4'd0;
      len_acc_q  <= 64'd0;
      pay_left_q <= 64'd0;
      mask_key_q <= '{default: 8'd0};
      mask_idx_q <= 2'd0;
      masked_q   <= 1'b0;
      fin_q      <= 1'b1;
      prev_fin_q <= 1'b1;
      opcode_q   <= 4'd0;
      held_op_q  <= 4'd0;
    end else begin
      phase_q    <= phase_d;
      ext_left_q <= ext_left_d;
      len_acc_q  <= len_acc_d;
      pay_left_q <= pay_left_d;
      mask_key_q <= mask_key_d;
      mask_idx_q <= mask_idx_d;
      masked_q   <= masked_d;
      fin_q      <= fin_d;
      prev_fin_q <= prev_fin_d;
      opcode_q   <= opcode_d;
      held_op_q  <= held_op_d;
    end
  end

endmodule

// ----- hdl/wsd_out_buf.sv -----
// ----------------------------------------------------------------------------
// wsd_out_buf: two-entry result register with skid slot
// Holds results until the receiver takes them; signals full to the input side.
// ----------------------------------------------------------------------------
module wsd_out_buf
  import wsd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        wr_valid_i,
  input  wsd_result_t wr_data_i,
  output logic        full_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output wsd_result_t out_data_o
);

  wsd_result_t entry_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  count_q;
  logic        rd_fire;

  assign out_valid_o = (count_q != 2'd0);
  assign full_o      = (count_q == 2'd2);
  assign rd_fire     = out_valid_o && !out_stall_i;
  assign out_data_o  = entry_q[rd_ptr_q];

  // Store result payload
  always_ff @(posedge clk_i) begin
    if (wr_valid_i) begin
      entry_q[wr_ptr_q] <= wr_data_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (wr_valid_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (rd_fire) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      case ({wr_valid_i, rd_fire})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ----- hdl/websocket_frame_deframer.sv -----
// ----------------------------------------------------------------------------
// websocket_frame_deframer: receive-side WebSocket frame parser
// Splits a byte stream into frame headers and unmasked payload bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel rx_*: one stream byte per request (rx_valid_i, rx_stall_o).
//   Output channel out_*: one result per request (out_valid_o, out_stall_i).
//   Header bytes yield nothing until the header is complete; then a header
//   result (item_kind 0) carries opcode, length, FIN and the missing-fragment
//   flag. Each payload byte then yields one data result (item_kind 1).
//   Output: each result is registered in the result buffer before it is shown.
//   Throughput: one byte per cycle while rx_stall_o is low; the two-entry
//   result buffer lets a byte be taken while a result waits.
//   Stall: results are held in the buffer; rx_stall_o rises once both
//   entries are occupied, and the parser holds its state meanwhile.
//   Reset: parser expects the first header byte, FIN history is set,
//   held opcode and mask key are zero, and the buffer is empty.
// ----------------------------------------------------------------------------
module websocket_frame_deframer
  import wsd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        rx_valid_i,
  output logic        rx_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        item_kind_o,
  output logic [7:0]  payload_byte_o,
  output logic [3:0]  message_opcode_o,
  output logic [63:0] frame_length_o,
  output logic        final_fragment_o,
  output logic        message_end_o,
  output logic        missing_fragment_o
);

  logic        buf_full;
  logic        rx_fire;
  logic        res_valid;
  wsd_result_t res;
  wsd_result_t out_res;

  assign rx_stall_o = buf_full;
  assign rx_fire    = rx_valid_i && !buf_full;

  // Parse one byte per request
  wsd_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (rx_fire),
    .byte_i       (rx_byte_i),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  // Hold results for the receiver
  wsd_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_valid_i  (res_valid),
    .wr_data_i   (res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_res)
  );

  assign item_kind_o        = out_res.item_kind;
  assign payload_byte_o     = out_res.payload_byte;
  assign message_opcode_o   = out_res.message_opcode;
  assign frame_length_o     = out_res.frame_length;
  assign final_fragment_o   = out_res.final_fragment;
  assign message_end_o      = out_res.message_end;
  assign missing_fragment_o = out_res.missing_fragment;

endmodule
